/* rtl/core/swcr_pkg.sv */
`timescale 1ns / 1ps

package swcr_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_HEADER = 2'd1,
    ACT_BYTE = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PKT_META = 2'd0,
    PKT_DATA = 2'd1,
    PKT_DONE = 2'd2,
    PKT_OTHER = 2'd3
  } pkt_type_t;

  typedef enum logic [1:0] {
    ACK_META = 2'd0,
    ACK_DATA = 2'd1,
    ACK_DONE = 2'd2
  } ack_type_t;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_STOPPED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_AWAIT_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_SESSION_ID = 3'd0,
    REG_CHUNK_COUNT = 3'd1,
    REG_META_SEQ = 3'd2,
    REG_EXPECTED_DIGEST = 3'd3,
    REG_DIGEST_GIVEN = 3'd4
  } reg_index_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    action_t     kind;
    logic        hdr_good;
    pkt_type_t   ptype;
    logic [31:0] pkt_seq;
    logic [7:0]  data_byte;
  } q_entry_t;

  // Multiplying by the FNV prime 2^40 + 2^8 + 0xb3 reduces to shifts and adds.
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* rtl/core/swcr_if.sv */
`timescale 1ns / 1ps

interface swcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        decoded_ok;
  logic [1:0]  pkt_type;
  logic [31:0] pkt_session;
  logic [31:0] pkt_seq;
  logic [7:0]  data_byte;
  modport source (output valid, action, decoded_ok, pkt_type, pkt_session, pkt_seq,
                  data_byte, input ready);
  modport sink (input valid, action, decoded_ok, pkt_type, pkt_session, pkt_seq,
                data_byte, output ready);
endinterface

interface swcr_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [1:0]  send_type;
  logic [31:0] send_seq;
  logic        write_valid;
  logic [7:0]  write_byte;
  logic        finished;
  logic [1:0]  status;
  logic [63:0] digest;
  modport source (output valid, send_valid, send_type, send_seq, write_valid, write_byte,
                  finished, status, digest, input ready);
  modport sink (input valid, send_valid, send_type, send_seq, write_valid, write_byte,
                finished, status, digest, output ready);
endinterface

interface swcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/swcr_front.sv */
`timescale 1ns / 1ps

module swcr_front (
  input  logic               clk,
  input  logic               rst,
  swcr_in_if.sink            item,
  input  logic [31:0]        session_id,
  output logic               q_valid,
  output swcr_pkg::q_entry_t q_head,
  input  logic               q_pop
);
  import swcr_pkg::*;

  q_entry_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  q_entry_t   entry;

  // Classification: header validity is settled here, once per item.
  always_comb begin
    entry.kind      = action_t'(item.action);
    entry.hdr_good  = item.decoded_ok && (item.pkt_session == session_id);
    entry.ptype     = pkt_type_t'(item.pkt_type);
    entry.pkt_seq   = item.pkt_seq;
    entry.data_byte = item.data_byte;
  end

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_head     = mem[rd_ptr];

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

/* rtl/core/swcr_back.sv */
`timescale 1ns / 1ps

module swcr_back (
  input  logic               clk,
  input  logic               rst,
  swcr_cfg_if.sink           cfg,
  output logic [31:0]        session_id,
  input  logic               q_valid,
  input  swcr_pkg::q_entry_t q_head,
  output logic               q_pop,
  swcr_out_if.source         result
);
  import swcr_pkg::*;

  logic [31:0] chunk_count;
  logic [31:0] meta_seq;
  logic [63:0] expected_digest;
  logic        digest_given;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      ph_eff;
  logic [31:0] want_seq;
  logic [31:0] want_seq_next;
  logic [63:0] running_hash;
  logic [63:0] running_hash_next;
  logic        take_payload;
  logic        take_payload_next;
  logic        hdr_live;
  logic        seq_hit;

  logic        o_send_valid;
  ack_type_t   o_send_type;
  logic [31:0] o_send_seq;
  logic        o_write_valid;
  logic [7:0]  o_write_byte;
  logic        o_finished;
  status_t     o_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_id      <= 32'd0;
      chunk_count     <= 32'd0;
      meta_seq        <= 32'd0;
      expected_digest <= 64'd0;
      digest_given    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_SESSION_ID:      session_id <= cfg.data[31:0];
        REG_CHUNK_COUNT:     chunk_count <= cfg.data[31:0];
        REG_META_SEQ:        meta_seq <= cfg.data[31:0];
        REG_EXPECTED_DIGEST: expected_digest <= cfg.data;
        REG_DIGEST_GIVEN:    digest_given <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign q_pop = q_valid && (!result.valid || result.ready);

  // A receiving session whose count has been passed behaves as awaiting done.
  assign ph_eff   = (phase == PH_DATA && want_seq > chunk_count) ? PH_AWAIT_DONE : phase;
  assign hdr_live = (ph_eff != PH_IDLE) && q_head.hdr_good;
  assign seq_hit  = (q_head.pkt_seq == want_seq);

  // Next state.
  always_comb begin
    phase_next        = ph_eff;
    want_seq_next     = want_seq;
    running_hash_next = running_hash;
    take_payload_next = take_payload;
    unique case (q_head.kind)
      ACT_START: begin
        want_seq_next     = 32'd1;
        running_hash_next = FNV_BASIS;
        take_payload_next = 1'b0;
        phase_next        = (chunk_count == 32'd0) ? PH_AWAIT_DONE : PH_DATA;
      end
      ACT_HEADER: begin
        take_payload_next = 1'b0;
        if (hdr_live && q_head.ptype == PKT_DATA && ph_eff == PH_DATA && seq_hit) begin
          take_payload_next = 1'b1;
          if (want_seq >= chunk_count) begin
            phase_next = PH_AWAIT_DONE;
          end
          want_seq_next = want_seq + 32'd1;
        end else if (hdr_live && q_head.ptype == PKT_DONE && ph_eff == PH_AWAIT_DONE) begin
          phase_next = PH_IDLE;
        end
      end
      ACT_BYTE: begin
        if (take_payload) begin
          running_hash_next = fnv_step(running_hash, q_head.data_byte);
        end
      end
      ACT_STOP: begin
        phase_next        = PH_IDLE;
        take_payload_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Result fields.
  always_comb begin
    o_send_valid  = 1'b0;
    o_send_type   = ACK_META;
    o_send_seq    = 32'd0;
    o_write_valid = 1'b0;
    o_write_byte  = 8'd0;
    o_finished    = 1'b0;
    o_status      = ST_SUCCESS;
    unique case (q_head.kind)
      ACT_START: begin
        o_send_valid = 1'b1;
        o_send_seq   = meta_seq;
      end
      ACT_HEADER: begin
        if (hdr_live && q_head.ptype == PKT_META) begin
          o_send_valid = 1'b1;
          o_send_seq   = meta_seq;
        end else if (hdr_live && q_head.ptype == PKT_DATA && ph_eff == PH_DATA) begin
          o_send_valid = 1'b1;
          o_send_type  = ACK_DATA;
          o_send_seq   = q_head.pkt_seq;
        end else if (hdr_live && q_head.ptype == PKT_DONE && ph_eff == PH_AWAIT_DONE) begin
          o_send_valid = 1'b1;
          o_send_type  = ACK_DONE;
          o_send_seq   = q_head.pkt_seq;
          o_finished   = 1'b1;
          o_status     = (digest_given && running_hash != expected_digest) ?
                         ST_MISMATCH : ST_SUCCESS;
        end
      end
      ACT_BYTE: begin
        if (take_payload) begin
          o_write_valid = 1'b1;
          o_write_byte  = q_head.data_byte;
        end
      end
      ACT_STOP: begin
        if (ph_eff != PH_IDLE) begin
          o_finished = 1'b1;
          o_status   = ST_STOPPED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      want_seq     <= 32'd1;
      running_hash <= FNV_BASIS;
      take_payload <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        want_seq     <= want_seq_next;
        running_hash <= running_hash_next;
        take_payload <= take_payload_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.send_valid  <= o_send_valid;
      result.send_type   <= o_send_type;
      result.send_seq    <= o_send_seq;
      result.write_valid <= o_write_valid;
      result.write_byte  <= o_write_byte;
      result.finished    <= o_finished;
      result.status      <= o_status;
      result.digest      <= running_hash_next;
    end
  end

  a_ack_or_write: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.send_valid && result.write_valid))
    else $error("ack and write byte in one result");

  a_status_needs_finish: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.finished) |-> (result.status == ST_SUCCESS))
    else $error("status set on an unfinished result");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == ACT_START) |=> (phase != PH_IDLE && !take_payload))
    else $error("start did not open a session");

  a_pop_has_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && (!result.valid || result.ready)))
    else $error("queue popped without output room");

endmodule

/* rtl/core/stop_and_wait_chunk_receiver.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Carries
// item     in   valid / ready    action, decoded_ok, pkt_type, pkt_session, pkt_seq, data_byte
// result   out  valid / ready    send_*, write_*, finished, status, digest
// cfg      in   valid / ready    index (register number), data
//
// One item per cycle sustained while results are taken; each item yields exactly one result
// after its transfer, passing through the front queue and then the back output register.
// The figure is set by the back stage, which updates the session state and folds one byte
// into the FNV-1a hash per cycle.
// Reset (rst, synchronous) empties the queue, drops the result and returns the session to
// idle with the hash at the offset basis; no clearing pass is needed.
// A stalled result holds the back stage; the two-entry queue keeps taking items until full.

module stop_and_wait_chunk_receiver (
  input  logic       clk,
  input  logic       rst,
  swcr_in_if.sink    item,
  swcr_out_if.source result,
  swcr_cfg_if.sink   cfg
);
  import swcr_pkg::*;

  // Between front and back: the head of the queue and its pop strobe.
  logic        q_valid;
  q_entry_t    q_head;
  logic        q_pop;
  logic [31:0] session_id;

  // The front takes every transfer into the queue and classifies it, including the
  // session check on headers.
  swcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .session_id (session_id),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  // The back holds the registers and session state and produces the result.
  swcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .session_id (session_id),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .result     (result)
  );

endmodule
